// File: hw/rtl/varint_batch_frame_deframer_unit_assert.svh
// assertion macros for the deframer checker
`ifndef VARINT_BATCH_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define VARINT_BATCH_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define VBFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vbfd_pkg.sv
package vbfd_pkg;

  // varint prefix bytes
  localparam logic [7:0] SMALL_MAX = 8'hFC;
  localparam logic [7:0] PFX_TWO   = 8'hFD;
  localparam logic [7:0] PFX_FOUR  = 8'hFE;

  // trailing byte counts after a prefix
  localparam logic [3:0] VLEN_TWO   = 4'd2;
  localparam logic [3:0] VLEN_FOUR  = 4'd4;
  localparam logic [3:0] VLEN_EIGHT = 4'd8;

  // entry cap after reset
  localparam logic [12:0] ENTRY_CAP_RESET = 13'd1024;

  typedef enum logic [1:0] {
    PH_CHAN = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_STOP = 2'd3
  } vbfd_phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_WIDE  = 2'd2,
    ST_CAP   = 2'd3
  } vbfd_status_t;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } vbfd_beat_t;

  // one result beat plus its presence flag
  typedef struct packed {
    logic         has_result;
    logic [7:0]   payload_byte;
    logic         byte_valid;
    logic [31:0]  channel;
    logic         message_first;
    logic         message_last;
    logic         frame_done;
    vbfd_status_t frame_status;
  } vbfd_result_t;

endpackage

// File: hw/rtl/vbfd_in_stage.sv
module vbfd_in_stage
  import vbfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_end,
  input  logic       take,
  output logic       beat_valid,
  output vbfd_beat_t beat
);

  logic       valid_r;
  vbfd_beat_t beat_r;

  // accept when empty or when the held beat moves on this cycle
  assign in_ready   = !valid_r || take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r.data_byte <= in_data_byte;
      beat_r.frame_end <= in_frame_end;
    end
  end

endmodule

// File: hw/rtl/vbfd_core.sv
module vbfd_core
  import vbfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  vbfd_beat_t   beat,
  input  logic         advance,
  input  logic         cfg_valid,
  input  logic [12:0]  cfg_max_entries,
  output vbfd_result_t res
);

  vbfd_phase_t  phase_r, phase_nxt;
  logic [3:0]   left_r, left_nxt;
  logic [2:0]   pos_r, pos_nxt;
  logic [63:0]  accum_r, accum_nxt;
  logic [31:0]  chan_r, chan_nxt;
  logic [63:0]  pay_left_r, pay_left_nxt;
  logic         first_r, first_nxt;
  logic [12:0]  count_r, count_nxt;
  vbfd_status_t err_r, err_nxt;
  logic [12:0]  max_entries_r;

  vbfd_status_t err_upd;
  logic [7:0]   b;
  logic         fe;
  logic         vi_start, vi_small, vi_done;
  logic [63:0]  vi_lanes, vi_value;
  logic [3:0]   vi_len;
  logic [13:0]  count_inc;
  logic         cap_hit;
  logic         pay_end;

  assign b  = beat.data_byte;
  assign fe = beat.frame_end;

  // varint byte decode
  assign vi_start = (left_r == 4'd0);
  assign vi_small = (b <= SMALL_MAX);
  assign vi_done  = vi_start ? vi_small : (left_r == 4'd1);
  assign vi_len   = (b == PFX_TWO) ? VLEN_TWO : (b == PFX_FOUR) ? VLEN_FOUR : VLEN_EIGHT;

  // drop the new byte into its little-endian lane
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      vi_lanes[i*8 +: 8] = (pos_r == 3'(i)) ? b : accum_r[i*8 +: 8];
    end
  end

  assign vi_value  = vi_start ? {56'd0, b} : vi_lanes;
  assign count_inc = {1'b0, count_r} + 14'd1;
  assign cap_hit   = (count_inc > {1'b0, max_entries_r});
  assign pay_end   = (pay_left_r == 64'd1);

  // next state
  always_comb begin
    vbfd_phase_t ph;
    logic [3:0]  left;
    logic [2:0]  pos;
    logic [63:0] acc;
    logic [31:0] chan;
    logic [63:0] pl;
    logic        first;
    logic [12:0] cnt;
    logic        feed;

    ph      = phase_r;
    left    = left_r;
    pos     = pos_r;
    acc     = accum_r;
    chan    = chan_r;
    pl      = pay_left_r;
    first   = first_r;
    cnt     = count_r;
    feed    = 1'b0;
    err_upd = err_r;

    unique case (phase_r)
      PH_CHAN: begin
        feed = 1'b1;
        if (vi_done) begin
          if (|vi_value[63:32]) begin
            err_upd = ST_WIDE;
            ph      = PH_STOP;
          end else begin
            chan = vi_value[31:0];
            ph   = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (vi_start && cap_hit) begin
          err_upd = ST_CAP;
          ph      = PH_STOP;
        end else begin
          if (vi_start) begin
            cnt = count_inc[12:0];
          end
          feed = 1'b1;
          if (vi_done) begin
            if (vi_value == 64'd0) begin
              ph = PH_CHAN;
            end else if (fe) begin
              err_upd = ST_TRUNC;
              ph      = PH_STOP;
            end else begin
              pl    = vi_value;
              first = 1'b1;
              ph    = PH_PAY;
            end
          end
        end
      end
      PH_PAY: begin
        first = 1'b0;
        pl    = pay_left_r - 64'd1;
        if (pay_end) begin
          ph = PH_LEN;
        end else if (fe) begin
          err_upd = ST_TRUNC;
          ph      = PH_STOP;
        end
      end
      PH_STOP: begin
      end
    endcase

    // varint shift state
    if (feed) begin
      if (vi_start) begin
        if (!vi_small) begin
          left = vi_len;
          acc  = 64'd0;
          pos  = 3'd0;
        end
      end else begin
        acc  = vi_lanes;
        pos  = pos_r + 3'd1;
        left = left_r - 4'd1;
      end
    end

    // frame end clears everything but the cap
    if (fe) begin
      phase_nxt    = PH_CHAN;
      left_nxt     = 4'd0;
      pos_nxt      = 3'd0;
      accum_nxt    = 64'd0;
      chan_nxt     = 32'd0;
      pay_left_nxt = 64'd0;
      first_nxt    = 1'b0;
      count_nxt    = 13'd0;
      err_nxt      = ST_OK;
    end else begin
      phase_nxt    = ph;
      left_nxt     = left;
      pos_nxt      = pos;
      accum_nxt    = acc;
      chan_nxt     = chan;
      pay_left_nxt = pl;
      first_nxt    = first;
      count_nxt    = cnt;
      err_nxt      = err_upd;
    end
  end

  // result for this beat
  always_comb begin
    res              = '0;
    res.frame_status = ST_OK;
    unique case (phase_r) inside
      PH_PAY: begin
        res.has_result    = 1'b1;
        res.byte_valid    = 1'b1;
        res.payload_byte  = b;
        res.channel       = chan_r;
        res.message_first = first_r;
        res.message_last  = pay_end;
      end
      PH_CHAN, PH_LEN, PH_STOP: begin
      end
    endcase
    if (fe) begin
      res.has_result   = 1'b1;
      res.frame_done   = 1'b1;
      res.frame_status = err_upd;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CHAN;
      left_r     <= 4'd0;
      pos_r      <= 3'd0;
      accum_r    <= 64'd0;
      chan_r     <= 32'd0;
      pay_left_r <= 64'd0;
      first_r    <= 1'b0;
      count_r    <= 13'd0;
      err_r      <= ST_OK;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      pos_r      <= pos_nxt;
      accum_r    <= accum_nxt;
      chan_r     <= chan_nxt;
      pay_left_r <= pay_left_nxt;
      first_r    <= first_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
    end
  end

  // entry cap register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= ENTRY_CAP_RESET;
    end else if (cfg_valid) begin
      max_entries_r <= cfg_max_entries;
    end
  end

endmodule

// File: hw/rtl/vbfd_out_stage.sv
module vbfd_out_stage
  import vbfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         beat_valid,
  input  vbfd_result_t res,
  output logic         load_ok,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_payload_byte,
  output logic         out_byte_valid,
  output logic [31:0]  out_channel,
  output logic         out_message_first,
  output logic         out_message_last,
  output logic         out_frame_done,
  output logic [1:0]   out_frame_status
);

  logic         valid_r;
  vbfd_result_t res_r;

  // result register takes a new beat when empty or being drained
  assign load_ok = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= beat_valid && res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      res_r <= res;
    end
  end

  // port fields
  assign out_valid         = valid_r;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_byte_valid    = res_r.byte_valid;
  assign out_channel       = res_r.channel;
  assign out_message_first = res_r.message_first;
  assign out_message_last  = res_r.message_last;
  assign out_frame_done    = res_r.frame_done;
  assign out_frame_status  = res_r.frame_status;

endmodule

// File: hw/rtl/varint_batch_frame_deframer_unit.sv
// Batch frame deframer: takes a frame body one byte per beat on the in_
// channel (in_frame_end marks the frame's last byte), decodes the channel id
// and length varints, and streams payload bytes on the out_ channel tagged
// with their channel and message first/last marks. Every frame-end byte
// gives one out_ beat with out_frame_done set and the frame status
// (0 ok, 1 message truncated, 2 channel id too wide, 3 entry cap exceeded).
// Header and length bytes give no out_ beat unless they end the frame.
// An accepted byte sits in the input register, is decoded combinationally,
// and its result, if any, raises out_valid once the result register loads it.
// Throughput: one byte per cycle while the result register is not stalled,
// set by the combinational decode between the input and result registers.
// A stalled out_ready holds the result register; the input register still
// takes one more byte, then in_ready drops until the result drains.
// Reset clears the decoder to "expect channel id", empties both registers
// and loads the entry cap with 1024. cfg_max_entries is written on any cfg_valid beat
// (cfg_ready is always high); the user must do so only while the block is idle, which the block does not check.
module varint_batch_frame_deframer_unit
  import vbfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_valid,
  output logic [31:0] out_channel,
  output logic        out_message_first,
  output logic        out_message_last,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_max_entries
);

  logic         beat_valid;
  vbfd_beat_t   beat;
  logic         load_ok;
  logic         advance;
  vbfd_result_t res;

  assign cfg_ready = 1'b1;
  assign advance   = beat_valid && load_ok;

  // input register
  vbfd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .take         (load_ok),
    .beat_valid   (beat_valid),
    .beat         (beat)
  );

  // varint and message decode
  vbfd_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat            (beat),
    .advance         (advance),
    .cfg_valid       (cfg_valid),
    .cfg_max_entries (cfg_max_entries),
    .res             (res)
  );

  // result register
  vbfd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .beat_valid        (beat_valid),
    .res               (res),
    .load_ok           (load_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_byte_valid    (out_byte_valid),
    .out_channel       (out_channel),
    .out_message_first (out_message_first),
    .out_message_last  (out_message_last),
    .out_frame_done    (out_frame_done),
    .out_frame_status  (out_frame_status)
  );

endmodule

// File: hw/rtl/vbfd_checker.sv
`include "varint_batch_frame_deframer_unit_assert.svh"

module vbfd_checker
  import vbfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_payload_byte,
  input logic        out_byte_valid,
  input logic [31:0] out_channel,
  input logic        out_message_first,
  input logic        out_message_last,
  input logic        out_frame_done,
  input logic [1:0]  out_frame_status
);

  // a stalled result beat holds
  `VBFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_byte) && $stable(out_channel) && $stable(out_frame_done) && $stable(out_frame_status), "stalled result beat changed")

  // a beat without payload is a frame end with all payload fields clear
  `VBFD_ASSERT_NOW(a_bare_frame_end, out_valid && !out_byte_valid, out_frame_done && out_payload_byte == 8'd0 && out_channel == 32'd0 && !out_message_first && !out_message_last, "result beat with neither payload nor frame end")

  // status only on frame end
  `VBFD_ASSERT_NOW(a_status_idle, out_valid && !out_frame_done, out_frame_status == ST_OK, "frame status set outside frame end")

  // payload on the frame's last byte: ok when it completes, else truncated
  `VBFD_ASSERT_NOW(a_last_byte_status, out_valid && out_byte_valid && out_frame_done, (out_message_last && out_frame_status == ST_OK) || (!out_message_last && out_frame_status == ST_TRUNC), "wrong status on payload at frame end")

endmodule

bind varint_batch_frame_deframer_unit vbfd_checker u_vbfd_checker (.*);

// File: tb/tb_varint_batch_frame_deframer_unit.sv
module tb_varint_batch_frame_deframer_unit;
  import vbfd_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [7:0]  PFX_EIGHT    = 8'hFF;

  // one out_ beat as the checker sees it
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic [31:0] chan;
    logic        first;
    logic        last;
    logic        done;
    logic [1:0]  status;
  } deframe_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_payload_byte;
  logic        out_byte_valid;
  logic [31:0] out_channel;
  logic        out_message_first;
  logic        out_message_last;
  logic        out_frame_done;
  logic [1:0]  out_frame_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_max_entries;

  // deframer state mirrored by the predictor
  vbfd_phase_t  dec_phase;
  vbfd_status_t err_code;
  logic [3:0]   vint_left;
  logic [63:0]  vint_acc;
  logic [6:0]   vint_pos;
  logic [31:0]  cur_chan;
  logic [63:0]  pay_left;
  logic         first_pend;
  logic [12:0]  entry_cnt;
  logic [12:0]  cap_reg;

  deframe_beat_t beats_due[$];
  logic [7:0]    frame_q[$];
  int            mismatch_cnt = 0;
  int            cycle_cnt = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  bit            gaps_on = 1'b0;
  bit            stall_on = 1'b0;
  logic [15:0]   stall_pat = 16'hA5C3;

  varint_batch_frame_deframer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_byte_valid    (out_byte_valid),
    .out_channel       (out_channel),
    .out_message_first (out_message_first),
    .out_message_last  (out_message_last),
    .out_frame_done    (out_frame_done),
    .out_frame_status  (out_frame_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_entries   (cfg_max_entries)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // back to "expect channel id" after every frame end
  function automatic void restart_frame();
    dec_phase  = PH_CHAN;
    err_code   = ST_OK;
    vint_left  = '0;
    vint_acc   = '0;
    vint_pos   = '0;
    cur_chan   = '0;
    pay_left   = '0;
    first_pend = 1'b0;
    entry_cnt  = '0;
  endfunction

  // one byte into the varint decoder, returns 1 when a value is complete
  function automatic logic varint_step(input logic [7:0] b, output logic [63:0] val);
    val = '0;
    if (vint_left == 0) begin
      if (b <= SMALL_MAX) begin
        val = {56'd0, b};
        return 1'b1;
      end
      vint_left = (b == PFX_TWO) ? VLEN_TWO : (b == PFX_FOUR) ? VLEN_FOUR : VLEN_EIGHT;
      vint_acc  = '0;
      vint_pos  = '0;
      return 1'b0;
    end
    vint_acc  = vint_acc | ({56'd0, b} << vint_pos[5:0]);
    vint_pos  = vint_pos + 7'd8;
    vint_left = vint_left - 4'd1;
    if (vint_left == 0) begin
      val = vint_acc;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected out_ beat, if any, for one accepted in_ beat
  function automatic void deframe_byte(input logic [7:0] b, input logic fe);
    logic [63:0]   v;
    deframe_beat_t r;
    logic          has;
    logic          capped;
    r      = '0;
    has    = 1'b0;
    capped = 1'b0;
    case (dec_phase)
      PH_CHAN: begin
        if (varint_step(b, v)) begin
          if (v > 64'hFFFF_FFFF) begin
            err_code  = ST_WIDE;
            dec_phase = PH_STOP;
          end else begin
            cur_chan  = v[31:0];
            dec_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        // first byte of a length varint counts against the cap
        if (vint_left == 0) begin
          if ({1'b0, entry_cnt} + 14'd1 > {1'b0, cap_reg}) begin
            err_code  = ST_CAP;
            dec_phase = PH_STOP;
            capped    = 1'b1;
          end else begin
            entry_cnt = entry_cnt + 13'd1;
          end
        end
        if (!capped) begin
          if (varint_step(b, v)) begin
            if (v == 0) begin
              dec_phase = PH_CHAN;
            end else if (fe) begin
              err_code  = ST_TRUNC;
              dec_phase = PH_STOP;
            end else begin
              pay_left   = v;
              first_pend = 1'b1;
              dec_phase  = PH_PAY;
            end
          end
        end
      end
      PH_PAY: begin
        r.data     = b;
        r.valid    = 1'b1;
        r.chan     = cur_chan;
        r.first    = first_pend;
        first_pend = 1'b0;
        pay_left   = pay_left - 64'd1;
        if (pay_left == 0) begin
          r.last    = 1'b1;
          dec_phase = PH_LEN;
        end else if (fe) begin
          err_code  = ST_TRUNC;
          dec_phase = PH_STOP;
        end
        has = 1'b1;
      end
      default: ;
    endcase
    if (fe) begin
      r.done   = 1'b1;
      r.status = err_code;
      has      = 1'b1;
      restart_frame();
    end
    if (has) beats_due.insert(beats_due.size(), r);
  endfunction

  function automatic string beat_str(input deframe_beat_t t);
    return $sformatf("byte=%02h bv=%0d ch=%08h first=%0d last=%0d done=%0d status=%0d",
                     t.data, t.valid, t.chan, t.first, t.last, t.done, t.status);
  endfunction

  // ---------------------------------------------------------------------
  // monitor: predict on in_ beats, check out_ beats
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    deframe_beat_t got;
    deframe_beat_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_max_entries;
      if (in_valid && in_ready) deframe_byte(in_data_byte, in_frame_end);
      if (out_valid && out_ready) begin
        got.data   = out_payload_byte;
        got.valid  = out_byte_valid;
        got.chan   = out_channel;
        got.first  = out_message_first;
        got.last   = out_message_last;
        got.done   = out_frame_done;
        got.status = out_frame_status;
        if (beats_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected out beat: %s", beat_str(got));
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("out beat mismatch\n  expected %s\n  actual   %s",
                       beat_str(want), beat_str(got));
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb_varint_batch_frame_deframer_unit NOT OK");
      $finish;
    end
  end

  // receiver back-pressure on a rotating pattern, reseeded now and then
  always @(negedge clk) begin
    if (!stall_on) begin
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 47) == 0) stall_pat = 16'($urandom) | 16'h0001;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      out_ready <= stall_pat[0];
    end
  end

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------

  // one in_ beat, with bursts and gaps when enabled
  task automatic send_byte(input logic [7:0] b, input logic fe);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    items_sent += frame_q.size();
  endtask

  // sender holds off until every expected beat is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_cap(input logic [12:0] cap);
    cfg_valid       <= 1'b1;
    cfg_max_entries <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // frame builders
  // ---------------------------------------------------------------------

  // append one byte to the frame under construction
  function automatic void add_frame_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  // form: 0 single byte, 1/2/3 for the 2/4/8 byte prefixes
  function automatic void put_varint(input logic [63:0] val, input int form);
    int nb;
    case (form)
      0: begin
        add_frame_byte(val[7:0]);
        return;
      end
      1: begin
        add_frame_byte(PFX_TWO);
        nb = 2;
      end
      2: begin
        add_frame_byte(PFX_FOUR);
        nb = 4;
      end
      default: begin
        add_frame_byte(PFX_EIGHT);
        nb = 8;
      end
    endcase
    for (int i = 0; i < nb; i++) add_frame_byte(val[8*i +: 8]);
  endfunction

  // any legal encoding, wider than needed at times
  function automatic void put_varint_any(input logic [63:0] val);
    int lo;
    lo = (val <= SMALL_MAX) ? 0 : (val <= 64'hFFFF) ? 1 : (val <= 64'hFFFF_FFFF) ? 2 : 3;
    if (lo == 0 && $urandom_range(0, 2) != 0) put_varint(val, 0);
    else put_varint(val, $urandom_range(lo, 3));
  endfunction

  function automatic logic [63:0] rand_chan();
    case ($urandom_range(0, 4)) inside
      0:       return 64'd0;
      [1:2]:   return 64'($urandom_range(0, SMALL_MAX));
      3:       return 64'($urandom_range(0, 16'hFFFF));
      default: return {32'd0, $urandom()};
    endcase
  endfunction

  // mostly well-formed frames, some cut short, some wide ids, some noise
  function automatic void build_frame();
    int          kind;
    int          len;
    int          keep;
    logic [31:0] hi;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      put_varint_any(rand_chan());
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) == 0) begin
          put_varint_any(64'd0);
          put_varint_any(rand_chan());
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
          put_varint_any(64'(len));
          repeat (len) add_frame_byte(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
    end else if (kind < 82) begin
      hi = $urandom();
      if (hi == 0) hi = 32'd1;
      put_varint({hi, $urandom()}, 3);
      repeat ($urandom_range(0, 6)) add_frame_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) add_frame_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic run_random_phase(input logic [12:0] cap, input int n_items,
                                  input bit gaps, input bit stalls);
    int start;
    set_entry_cap(cap);
    gaps_on  = gaps;
    stall_on = stalls;
    start    = items_sent;
    while (items_sent - start < n_items) begin
      build_frame();
      send_frame();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // plain frames at the reset cap, no idling on either side
  task automatic test_basic_frames();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    // one message whose last byte also ends the frame
    frame_q = {8'h07, 8'h02, 8'h00, 8'hFF};
    send_frame();
    // channel 0, then a switch marker to a two-byte id
    frame_q = {8'h00, 8'h01, 8'hAA, 8'h00, 8'hFD, 8'h34, 8'h12, 8'h01, 8'h55};
    send_frame();
    // frame of a single header byte
    frame_q = {SMALL_MAX};
    send_frame();
    drain_results();
  endtask

  task automatic test_header_edge_cases();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    // channel id above 32 bits stops the frame
    frame_q = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h33};
    send_frame();
    // largest channel id, length in the two-byte form
    frame_q = {8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFD, 8'h01, 8'h00, 8'h80};
    send_frame();
    // varint cut off by the frame end ends the frame with status ok
    frame_q = {8'hFE, 8'h01, 8'h02};
    send_frame();
    // message cut off after two of five bytes
    frame_q = {8'h01, 8'h05, 8'h11, 8'h22};
    send_frame();
    // nonzero length on the frame's last byte
    frame_q = {8'h01, 8'h03};
    send_frame();
    drain_results();
  endtask

  task automatic test_entry_cap_min();
    set_entry_cap(13'd1);
    // second length exceeds the cap
    frame_q = {8'h01, 8'h01, 8'h99, 8'h01, 8'h77};
    send_frame();
    // switch marker uses up the only entry
    frame_q = {8'h01, 8'h00, 8'h02, 8'h01, 8'h66};
    send_frame();
    drain_results();
  endtask

  task automatic test_random_max_cap();
    run_random_phase(13'd4096, 150, 1'b0, 1'b0);
    run_random_phase(13'd4096, 100, 1'b1, 1'b1);
  endtask

  task automatic test_random_min_cap();
    run_random_phase(13'd1, 120, 1'b1, 1'b1);
  endtask

  task automatic test_random_small_caps();
    run_random_phase(13'd2, 120, 1'b1, 1'b0);
    run_random_phase(13'd3, 120, 1'b0, 1'b1);
  endtask

  task automatic test_random_mixed_caps();
    run_random_phase(ENTRY_CAP_RESET, 120, 1'b1, 1'b1);
    run_random_phase(13'($urandom_range(1, 4096)), 100, 1'b1, 1'b1);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_frame_end    = 1'b0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_max_entries = ENTRY_CAP_RESET;
    cap_reg         = ENTRY_CAP_RESET;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_frames();
    test_header_edge_cases();
    test_entry_cap_min();
    test_random_max_cap();
    test_random_min_cap();
    test_random_small_caps();
    test_random_mixed_caps();

    if (mismatch_cnt == 0 && beats_due.size() == 0)
      $display("tb_varint_batch_frame_deframer_unit OK");
    else
      $display("tb_varint_batch_frame_deframer_unit NOT OK");
    $finish;
  end

endmodule
